// File: rtl/core/qpskpm_pkg.sv
package qpskpm_pkg;

    localparam int SAMPLES_PER_SYMBOL = 20;
    localparam int TAPS_PER_PHASE     = 6;
    localparam int TABLE_SIZE         = SAMPLES_PER_SYMBOL * TAPS_PER_PHASE;

    localparam int PHASE_W = 5;
    localparam int ADDR_W  = 7;
    localparam int COEF_W  = 16;
    localparam int AMP_W   = 15;
    localparam int GAIN_W  = 16;
    localparam int CFG_W   = 16;
    localparam int SAMP_W  = 16;
    localparam int TCNT_W  = $clog2(TAPS_PER_PHASE + 1);

    // sum of TAPS_PER_PHASE Q15 values, either sign
    localparam int ACC_W   = COEF_W + $clog2(TAPS_PER_PHASE) + 1;
    localparam int OPA_W   = ACC_W + AMP_W + 1;
    localparam int OPB_W   = GAIN_W + 1;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int PRODUCT_SHIFT = 27;

    localparam logic [AMP_W-1:0]  AMP_RESET  = AMP_W'(10000);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

    typedef enum logic
    {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } opcode_t;

    typedef enum logic
    {
        REG_AMPLITUDE = 1'b0,
        REG_GAIN      = 1'b1
    } reg_index_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_TAP,
        ST_MUL_AMP,
        ST_MUL_GAIN,
        ST_SAT
    } state_t;

endpackage

// File: rtl/core/qpskpm_coef_ram.sv
module qpskpm_coef_ram
(
    input  logic                              clk,
    input  logic                              we,
    input  logic [qpskpm_pkg::ADDR_W-1:0]     waddr,
    input  logic signed [qpskpm_pkg::COEF_W-1:0] wdata,
    input  logic                              re,
    input  logic [qpskpm_pkg::ADDR_W-1:0]     raddr,
    output logic signed [qpskpm_pkg::COEF_W-1:0] rdata
);
    import qpskpm_pkg::*;

    logic signed [COEF_W-1:0] mem [TABLE_SIZE];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/qpsk_polyphase_modulator_core.sv
// QPSK polyphase modulator, fs/4 carrier.
// Input channel (in_valid / in_stall): opcode, symbol_bits, coef_index,
// coef_value. A load transaction writes one Q15 coefficient (index 0..119,
// others ignored) and produces no result. A tick transaction produces one
// sample on the output channel (out_valid / out_stall).
// A tick walks the taps (six reads of the coefficient RAM, registered read
// data), then makes two passes through the shared multiplier (amplitude,
// then gain) and a round/saturate step before out_valid. in_stall is high
// while a tick is in progress and drops in the cycle after the sample is
// registered, so no new tick is accepted before that sample is registered.
// Registers are written through cfg_we / cfg_index / cfg_wdata; the user
// must write them only while idle, the block itself does not enforce it.
// Reset clears phase, sign lines, registers (amplitude 10000, gain 1.0)
// and the output valid; the coefficient table is not cleared and must be
// loaded before ticks use it. When the receiver stalls, the sample holds;
// the next tick is accepted and runs, waiting before its saturate step
// until the output register is free.
module qpsk_polyphase_modulator_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  opcode,
    input  logic [1:0]                            symbol_bits,
    input  logic [qpskpm_pkg::ADDR_W-1:0]         coef_index,
    input  logic signed [qpskpm_pkg::COEF_W-1:0]  coef_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [qpskpm_pkg::SAMP_W-1:0]  sample,
    input  logic                                  cfg_we,
    input  logic                                  cfg_index,
    input  logic [qpskpm_pkg::CFG_W-1:0]          cfg_wdata
);
    import qpskpm_pkg::*;

    localparam int PH_LAST  = SAMPLES_PER_SYMBOL - 1;
    localparam int PH_ISHFT = SAMPLES_PER_SYMBOL - 2;
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'((64'd1 << PRODUCT_SHIFT) - 1);
    localparam int Q_W = PROD_W - PRODUCT_SHIFT;
    localparam logic signed [Q_W-1:0] SAT_MAX = Q_W'(32767);
    localparam logic signed [Q_W-1:0] SAT_MIN = -Q_W'(32768);

    state_t state_reg, state_next;

    logic [AMP_W-1:0]   amp_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [TAPS_PER_PHASE-1:0] iline_reg, qline_reg;
    logic [TAPS_PER_PHASE-1:0] sgn_reg;
    logic [TCNT_W-1:0]  tap_cnt_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic               out_valid_reg;
    logic signed [SAMP_W-1:0] sample_reg;

    logic accept, tick_go, load_go, out_free, tap_issue;
    logic [TAPS_PER_PHASE-1:0] iline_ins, qline_ins, sel_line;
    logic carrier_neg;
    logic signed [COEF_W-1:0] rdata;
    logic signed [ACC_W-1:0]  coef_ext;
    logic signed [OPA_W-1:0]  op_a;
    logic signed [OPB_W-1:0]  op_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] biased;
    logic signed [Q_W-1:0]    q_val;
    logic signed [SAMP_W-1:0] sat_val;

    assign accept   = in_valid && !in_stall;
    assign tick_go  = accept && (opcode == OP_TICK);
    assign load_go  = accept && (opcode == OP_LOAD) && (coef_index < ADDR_W'(TABLE_SIZE));
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        iline_ins = iline_reg;
        qline_ins = qline_reg;
        if (phase_reg == '0)
        begin
            iline_ins[0] = symbol_bits[0];
            qline_ins[0] = symbol_bits[1];
        end
    end

    // phase mod 4: 0 +I, 1 -Q, 2 -I, 3 +Q
    assign sel_line    = phase_reg[0] ? qline_ins : iline_ins;
    assign carrier_neg = phase_reg[0] ^ phase_reg[1];

    qpskpm_coef_ram u_ram
    (
        .clk   (clk),
        .we    (load_go),
        .waddr (coef_index),
        .wdata (coef_value),
        .re    (tap_issue),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_go)
                begin
                    state_next = ST_TAP;
                end
            end
            ST_TAP:
            begin
                if (tap_cnt_reg == TCNT_W'(TAPS_PER_PHASE))
                begin
                    state_next = ST_MUL_AMP;
                end
            end
            ST_MUL_AMP:  state_next = ST_MUL_GAIN;
            ST_MUL_GAIN: state_next = ST_SAT;
            ST_SAT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        tap_issue = 1'b0;
        op_a      = '0;
        op_b      = '0;
        unique case (state_reg)
            ST_IDLE:     in_stall = 1'b0;
            ST_TAP:      tap_issue = (tap_cnt_reg < TCNT_W'(TAPS_PER_PHASE));
            ST_MUL_AMP:
            begin
                op_a = OPA_W'(acc_reg);
                op_b = $signed({1'b0, {(OPB_W-AMP_W-1){1'b0}}, amp_reg});
            end
            ST_MUL_GAIN:
            begin
                op_a = prod_reg[OPA_W-1:0];
                op_b = $signed({1'b0, gain_reg});
            end
            ST_SAT:      in_stall = 1'b1;
            default:     in_stall = 1'b1;
        endcase
    end

    // shared multiplier
    assign mul_p    = op_a * op_b;
    assign coef_ext = ACC_W'(rdata);

    // truncate toward zero, then saturate
    assign biased = prod_reg + (prod_reg[PROD_W-1] ? ROUND_BIAS : '0);
    assign q_val  = biased[PROD_W-1:PRODUCT_SHIFT];
    always_comb
    begin
        priority if (q_val > SAT_MAX)
        begin
            sat_val = SAT_MAX[SAMP_W-1:0];
        end
        else if (q_val < SAT_MIN)
        begin
            sat_val = SAT_MIN[SAMP_W-1:0];
        end
        else
        begin
            sat_val = q_val[SAMP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            amp_reg       <= AMP_RESET;
            gain_reg      <= GAIN_RESET;
            phase_reg     <= '0;
            iline_reg     <= '0;
            qline_reg     <= '0;
            tap_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_AMPLITUDE: amp_reg  <= cfg_wdata[AMP_W-1:0];
                    REG_GAIN:      gain_reg <= cfg_wdata[GAIN_W-1:0];
                    default:       amp_reg  <= amp_reg;
                endcase
            end
            if (tick_go)
            begin
                tap_cnt_reg <= '0;
                if (phase_reg == PHASE_W'(PH_ISHFT))
                begin
                    iline_reg <= {iline_ins[TAPS_PER_PHASE-2:0], iline_ins[0]};
                end
                else
                begin
                    iline_reg <= iline_ins;
                end
                if (phase_reg == PHASE_W'(PH_LAST))
                begin
                    qline_reg <= {qline_ins[TAPS_PER_PHASE-2:0], qline_ins[0]};
                    phase_reg <= '0;
                end
                else
                begin
                    qline_reg <= qline_ins;
                    phase_reg <= phase_reg + PHASE_W'(1);
                end
            end
            else if (state_reg == ST_TAP)
            begin
                tap_cnt_reg <= tap_cnt_reg + TCNT_W'(1);
            end
            if (state_reg == ST_SAT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_go)
        begin
            acc_reg  <= '0;
            addr_reg <= ADDR_W'(phase_reg);
            sgn_reg  <= sel_line ^ {TAPS_PER_PHASE{carrier_neg}};
        end
        else if (state_reg == ST_TAP)
        begin
            if (tap_issue)
            begin
                addr_reg <= addr_reg + ADDR_W'(SAMPLES_PER_SYMBOL);
            end
            if (tap_cnt_reg != '0)
            begin
                acc_reg <= sgn_reg[0] ? (acc_reg - coef_ext) : (acc_reg + coef_ext);
                sgn_reg <= {1'b0, sgn_reg[TAPS_PER_PHASE-1:1]};
            end
        end
        if (state_reg == ST_MUL_AMP || state_reg == ST_MUL_GAIN)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_SAT && out_free)
        begin
            sample_reg <= sat_val;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

endmodule

// File: rtl/core/qpskpm_checker.sv
module qpskpm_checker
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic                                  opcode,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic signed [qpskpm_pkg::SAMP_W-1:0]  sample
);
    import qpskpm_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample))
        else $error("stalled sample changed or dropped");

    // a tick transaction keeps the input side busy
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_TICK |=> in_stall)
        else $error("input ready right after tick");

    // a load transaction leaves the input side free in the cycle after it
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_LOAD |=> !in_stall)
        else $error("input stalled after load");

    // a tick cannot finish in the cycle after acceptance
    a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_TICK && !out_valid |=> !out_valid)
        else $error("sample too early");

endmodule

bind qpsk_polyphase_modulator_core qpskpm_checker u_qpskpm_checker (.*);

// File: tb/sv/tb_qpsk_polyphase_modulator_core.sv
module tb_qpsk_polyphase_modulator_core;

    import qpskpm_pkg::*;

    localparam int IDLE_SETTLE = 16;
    localparam int DRAIN_LIMIT = 5000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       opcode = OP_TICK;
    logic [1:0]                 symbol_bits = '0;
    logic [ADDR_W-1:0]          coef_index = '0;
    logic signed [COEF_W-1:0]   coef_value = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMP_W-1:0]   sample;
    logic                       cfg_we = 1'b0;
    logic                       cfg_index = REG_AMPLITUDE;
    logic [CFG_W-1:0]           cfg_wdata = '0;

    // modulator state as the testbench sees it
    logic [AMP_W-1:0]           level_amp = AMP_RESET;
    logic [GAIN_W-1:0]          level_gain = GAIN_RESET;
    logic [PHASE_W-1:0]         phase = '0;
    logic [TAPS_PER_PHASE-1:0]  i_signs = '0;
    logic [TAPS_PER_PHASE-1:0]  q_signs = '0;
    logic signed [COEF_W-1:0]   coef_table [TABLE_SIZE];

    logic signed [SAMP_W-1:0]   pending_samples [$];
    logic signed [SAMP_W-1:0]   want;
    int                         error_count = 0;
    int                         stall_left = 0;
    bit                         idle_on = 1'b1;
    bit                         quiet = 1'b0;

    qpsk_polyphase_modulator_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .symbol_bits (symbol_bits),
        .coef_index  (coef_index),
        .coef_value  (coef_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always #5 clk = ~clk;

    task automatic modulate_item(opcode_t op, logic [1:0] bits, logic [ADDR_W-1:0] idx,
                                 logic signed [COEF_W-1:0] value);
        int                         acc;
        int                         c;
        longint                     prod;
        longint                     mag;
        logic [TAPS_PER_PHASE-1:0]  line;
        logic signed [SAMP_W-1:0]   result;
        if (op == OP_LOAD)
        begin
            if (idx < TABLE_SIZE)
                coef_table[idx] = value;
        end
        else
        begin
            if (phase == 0)
            begin
                i_signs[0] = bits[0];
                q_signs[0] = bits[1];
            end
            line = (phase[0] == 1'b0) ? i_signs : q_signs;
            acc = 0;
            for (int k = 0; k < TAPS_PER_PHASE; k++)
            begin
                c = int'(coef_table[int'(phase) + SAMPLES_PER_SYMBOL * k]);
                acc += line[k] ? -c : c;
            end
            // fs/4 carrier: +I, -Q, -I, +Q
            if (phase[1:0] == 2'd1 || phase[1:0] == 2'd2)
                acc = -acc;
            if (phase == SAMPLES_PER_SYMBOL - 2)
            begin
                i_signs = {i_signs[TAPS_PER_PHASE-2:0], i_signs[0]};
                phase = phase + PHASE_W'(1);
            end
            else if (phase == SAMPLES_PER_SYMBOL - 1)
            begin
                q_signs = {q_signs[TAPS_PER_PHASE-2:0], q_signs[0]};
                phase = '0;
            end
            else
                phase = phase + PHASE_W'(1);
            prod = longint'(acc) * longint'(level_amp) * longint'(level_gain);
            mag = (prod < 0) ? -prod : prod;
            mag = mag >> PRODUCT_SHIFT;
            if (prod < 0)
                result = (mag > 64'sd32768) ? 16'sh8000 : SAMP_W'(-mag);
            else
                result = (mag > 64'sd32767) ? 16'sh7fff : SAMP_W'(mag);
            pending_samples.push_back(result);
        end
    endtask

    task automatic send_item(opcode_t op, logic [1:0] bits, logic [ADDR_W-1:0] idx,
                             logic signed [COEF_W-1:0] value);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        symbol_bits <= bits;
        coef_index  <= idx;
        coef_value  <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        modulate_item(op, bits, idx, value);
    endtask

    task automatic set_levels(logic [AMP_W-1:0] amp, logic [GAIN_W-1:0] gain);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_AMPLITUDE;
        cfg_wdata <= CFG_W'(amp);
        @(posedge clk);
        cfg_index <= REG_GAIN;
        cfg_wdata <= CFG_W'(gain);
        @(posedge clk);
        cfg_we <= 1'b0;
        level_amp  = amp;
        level_gain = gain;
    endtask

    function automatic logic signed [COEF_W-1:0] random_coef();
        logic signed [COEF_W-1:0] v;
        int                       r;
        v = COEF_W'($urandom);
        r = $urandom_range(0, 7);
        if (r == 0)
            v = 16'sh7fff;
        else if (r == 1)
            v = 16'sh8000;
        else if (r < 5)
            v = v >>> 3;
        return v;
    endfunction

    task automatic send_tick(logic [1:0] bits);
        send_item(OP_TICK, bits, ADDR_W'($urandom), COEF_W'($urandom));
    endtask

    task automatic test_table_load();
        for (int i = 0; i < TABLE_SIZE; i++)
            send_item(OP_LOAD, 2'($urandom), ADDR_W'(i), random_coef());
    endtask

    // full-scale taps on phase 0, extreme levels, one pass over all carrier signs
    task automatic test_carrier_phases();
        set_levels(AMP_W'(32767), GAIN_W'(65535));
        for (int k = 0; k < TAPS_PER_PHASE; k++)
            send_item(OP_LOAD, 2'b00, ADDR_W'(SAMPLES_PER_SYMBOL * k), 16'sh8000);
        send_tick(2'b11);
        for (int i = 1; i < 4; i++)
            send_tick(2'($urandom));
    endtask

    task automatic test_zero_scaling();
        set_levels('0, GAIN_W'(65535));
        send_tick(2'($urandom));
        send_tick(2'($urandom));
        set_levels(AMP_W'(32767), '0);
        send_tick(2'($urandom));
        send_tick(2'($urandom));
    endtask

    task automatic test_ignored_loads();
        set_levels(AMP_RESET, GAIN_RESET);
        send_item(OP_LOAD, 2'b11, ADDR_W'(TABLE_SIZE), 16'sh7fff);
        send_item(OP_LOAD, 2'b00, 7'h7f, 16'sh8000);
        for (int i = 0; i < 3; i++)
            send_tick(2'($urandom));
    endtask

    task automatic test_random_levels(logic [AMP_W-1:0] amp, logic [GAIN_W-1:0] gain,
                                      int count);
        int r;
        set_levels(amp, gain);
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                send_tick(2'($urandom));
            else if (r < 95)
                send_item(OP_LOAD, 2'($urandom), ADDR_W'($urandom_range(0, TABLE_SIZE - 1)),
                          random_coef());
            else
                send_item(OP_LOAD, 2'($urandom), ADDR_W'($urandom_range(TABLE_SIZE, 127)),
                          random_coef());
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 7);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("unexpected sample transaction: sample %0d", sample);
                error_count++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (sample !== want)
                begin
                    $error("sample mismatch: expected %0d, actual %0d", want, sample);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int waited;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_carrier_phases();
        test_zero_scaling();
        test_ignored_loads();
        test_random_levels(AMP_RESET, GAIN_RESET, 100);
        test_random_levels(AMP_W'($urandom_range(0, 32767)),
                           GAIN_W'($urandom_range(0, 65535)), 100);
        test_random_levels(AMP_W'(32767), GAIN_W'(65535), 100);
        test_random_levels(AMP_W'($urandom_range(1, 300)),
                           GAIN_W'($urandom_range(0, 4095)), 100);
        idle_on = 1'b0;
        quiet = 1'b1;
        test_random_levels(AMP_W'($urandom_range(0, 32767)),
                           GAIN_W'($urandom_range(0, 65535)), 110);

        in_valid <= 1'b0;
        waited = 0;
        while (pending_samples.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (IDLE_SETTLE) @(posedge clk);
        if (pending_samples.size() != 0)
        begin
            $error("%0d expected sample transactions never arrived", pending_samples.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
